/* rtl/slle_pkg.sv */
// Shared constants, types and helpers for the static linked list engine.
package slle_pkg;

	// Store geometry
	localparam int ENTRIES = 16;
	localparam int SLOT_W  = $clog2(ENTRIES);
	localparam int LINK_W  = $clog2(ENTRIES + 2);
	localparam int CNT_W   = $clog2(ENTRIES + 1);
	localparam int PAY_W   = 64;

	typedef logic [SLOT_W-1:0] slot_t;
	typedef logic [LINK_W-1:0] link_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [PAY_W-1:0]  pay_t;
	typedef logic [2:0]        kind_t;
	typedef logic [1:0]        status_t;

	// Link codes beyond the slot range
	localparam link_t END_LINK  = LINK_W'(ENTRIES);
	localparam link_t FREE_LINK = LINK_W'(ENTRIES + 1);

	// Operation codes
	localparam kind_t K_ADD_HEAD  = 3'd0;
	localparam kind_t K_ADD_AFTER = 3'd1;
	localparam kind_t K_ADD_TAIL  = 3'd2;
	localparam kind_t K_DEL_HEAD  = 3'd3;
	localparam kind_t K_DEL_AFTER = 3'd4;
	localparam kind_t K_DEL_TAIL  = 3'd5;
	localparam kind_t K_READ      = 3'd6;

	// Status codes
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;
	localparam status_t ST_BAD   = 2'd3;

	// Any link outside the slot range reads as end of list
	function automatic link_t next_link(input link_t l);
		return (l < LINK_W'(ENTRIES)) ? l : END_LINK;
	endfunction

endpackage

/* rtl/slle_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module slle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* rtl/static_linked_list_engine_unit.sv */
// Top level: linked list sequencer over a payload RAM and a link RAM.
// Steps: add head and errors found at decode finish in the decode state; read and
// del head finish in the read state; add after and del after also pass through the
// fix or victim state; tail operations walk the list one link per cycle.
// Throughput: one word at a time; busy stays high until the result is out,
// set by the one-read-per-cycle link RAM walk. Results cannot be stalled.
// Reset clears the head, count and free marks; RAM contents stay undefined.
module static_linked_list_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  slle_pkg::kind_t   kind,
	input  slle_pkg::slot_t   slot,
	input  slle_pkg::pay_t    payload,
	output logic              done,
	output slle_pkg::status_t status,
	output slle_pkg::slot_t   touched_slot,
	output slle_pkg::link_t   link_out,
	output slle_pkg::pay_t    payload_out,
	output slle_pkg::cnt_t    entry_count,
	output slle_pkg::link_t   head_slot
);
	import slle_pkg::*;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DEC  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_VIC  = 3'd3;
	localparam logic [2:0] S_FIX  = 3'd4;

	logic [2:0]         state_q, state_d;
	kind_t              op_q, op_d;
	slot_t              slot_q, slot_d;
	pay_t               pay_q, pay_d;
	slot_t              cur_q, cur_d;
	slot_t              prev_q, prev_d;
	slot_t              new_q, new_d;
	link_t              head_q, head_d;
	cnt_t               count_q, count_d;
	logic [ENTRIES-1:0] free_q, free_d;
	logic               done_q, done_d;
	status_t            res_status_q, res_status_d;
	slot_t              res_touched_q, res_touched_d;
	link_t              res_link_q, res_link_d;
	pay_t               res_pay_q, res_pay_d;

	// RAM ports
	logic  rd_en;
	slot_t rd_addr;
	logic  lk_we;
	slot_t lk_waddr;
	link_t lk_wdata;
	link_t lk_rdata;
	logic  pl_we;
	pay_t  pl_rdata;

	logic  empty;
	logic  full;
	logic  slot_ok;
	slot_t low_idx;
	link_t nl;

	slle_ram #(
		.WIDTH (LINK_W),
		.DEPTH (ENTRIES)
	) u_link_ram (
		.clk   (clk),
		.we    (lk_we),
		.waddr (lk_waddr),
		.wdata (lk_wdata),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (lk_rdata)
	);

	slle_ram #(
		.WIDTH (PAY_W),
		.DEPTH (ENTRIES)
	) u_pay_ram (
		.clk   (clk),
		.we    (pl_we),
		.waddr (low_idx),
		.wdata (pay_q),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (pl_rdata)
	);

	// list status
	assign empty   = (head_q == END_LINK);
	assign full    = (count_q == CNT_W'(ENTRIES));
	assign slot_ok = (LINK_W'(slot_q) < LINK_W'(ENTRIES)) && !free_q[slot_q];
	assign nl      = next_link(lk_rdata);

	// lowest free slot
	always_comb begin
		low_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				low_idx = SLOT_W'(i);
			end
		end
	end

	// sequencer; one operation at a time, so reads never overlap a write
	always_comb begin
		state_d       = state_q;
		op_d          = op_q;
		slot_d        = slot_q;
		pay_d         = pay_q;
		cur_d         = cur_q;
		prev_d        = prev_q;
		new_d         = new_q;
		head_d        = head_q;
		count_d       = count_q;
		free_d        = free_q;
		done_d        = 1'b0;
		res_status_d  = res_status_q;
		res_touched_d = res_touched_q;
		res_link_d    = res_link_q;
		res_pay_d     = res_pay_q;
		rd_en         = 1'b0;
		rd_addr       = cur_q;
		lk_we         = 1'b0;
		lk_waddr      = cur_q;
		lk_wdata      = nl;
		pl_we         = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					// append to an empty list is an add at the head
					op_d    = (kind == K_ADD_TAIL && empty) ? K_ADD_HEAD : kind;
					slot_d  = slot;
					pay_d   = payload;
					state_d = S_DEC;
				end
			end

			S_DEC: begin
				// error results carry zeros
				res_touched_d = '0;
				res_link_d    = '0;
				res_pay_d     = '0;
				unique case (op_q)
					K_ADD_HEAD: begin
						if (full) begin
							res_status_d = ST_FULL;
							done_d       = 1'b1;
							state_d      = S_IDLE;
						end else begin
							pl_we           = 1'b1;
							lk_we           = 1'b1;
							lk_waddr        = low_idx;
							lk_wdata        = head_q;
							free_d[low_idx] = 1'b0;
							count_d         = count_q + CNT_W'(1);
							head_d          = LINK_W'(low_idx);
							res_status_d    = ST_OK;
							res_touched_d   = low_idx;
							res_link_d      = head_q;
							done_d          = 1'b1;
							state_d         = S_IDLE;
						end
					end
					K_ADD_AFTER: begin
						if (!slot_ok || full) begin
							res_status_d = !slot_ok ? ST_BAD : ST_FULL;
							done_d       = 1'b1;
							state_d      = S_IDLE;
						end else begin
							rd_en   = 1'b1;
							rd_addr = slot_q;
							cur_d   = slot_q;
							state_d = S_RD;
						end
					end
					K_ADD_TAIL: begin
						if (full) begin
							res_status_d = ST_FULL;
							done_d       = 1'b1;
							state_d      = S_IDLE;
						end else begin
							rd_en   = 1'b1;
							rd_addr = head_q[SLOT_W-1:0];
							cur_d   = head_q[SLOT_W-1:0];
							state_d = S_RD;
						end
					end
					K_DEL_HEAD, K_DEL_TAIL: begin
						if (empty) begin
							res_status_d = ST_EMPTY;
							done_d       = 1'b1;
							state_d      = S_IDLE;
						end else begin
							rd_en   = 1'b1;
							rd_addr = head_q[SLOT_W-1:0];
							cur_d   = head_q[SLOT_W-1:0];
							state_d = S_RD;
						end
					end
					K_DEL_AFTER, K_READ: begin
						if (!slot_ok) begin
							res_status_d = ST_BAD;
							done_d       = 1'b1;
							state_d      = S_IDLE;
						end else begin
							rd_en   = 1'b1;
							rd_addr = slot_q;
							cur_d   = slot_q;
							state_d = S_RD;
						end
					end
					default: begin
						res_status_d = ST_BAD;
						done_d       = 1'b1;
						state_d      = S_IDLE;
					end
				endcase
			end

			S_RD: begin
				// link and payload of cur_q are on the read ports
				unique case (op_q)
					K_ADD_AFTER, K_ADD_TAIL: begin
						if (op_q == K_ADD_TAIL && nl != END_LINK) begin
							rd_en   = 1'b1;
							rd_addr = nl[SLOT_W-1:0];
							cur_d   = nl[SLOT_W-1:0];
						end else begin
							pl_we           = 1'b1;
							lk_we           = 1'b1;
							lk_waddr        = low_idx;
							lk_wdata        = nl;
							free_d[low_idx] = 1'b0;
							count_d         = count_q + CNT_W'(1);
							new_d           = low_idx;
							res_status_d    = ST_OK;
							res_touched_d   = low_idx;
							res_link_d      = nl;
							res_pay_d       = '0;
							state_d         = S_FIX;
						end
					end
					K_DEL_HEAD, K_DEL_TAIL: begin
						if (op_q == K_DEL_TAIL && nl != END_LINK) begin
							prev_d  = cur_q;
							rd_en   = 1'b1;
							rd_addr = nl[SLOT_W-1:0];
							cur_d   = nl[SLOT_W-1:0];
							state_d = S_VIC;
						end else begin
							// one-entry tail removal is a head removal
							head_d        = nl;
							free_d[cur_q] = 1'b1;
							count_d       = count_q - CNT_W'(1);
							res_status_d  = ST_OK;
							res_touched_d = cur_q;
							res_link_d    = FREE_LINK;
							res_pay_d     = pl_rdata;
							done_d        = 1'b1;
							state_d       = S_IDLE;
						end
					end
					K_DEL_AFTER: begin
						if (nl == END_LINK) begin
							res_status_d  = ST_EMPTY;
							res_touched_d = '0;
							res_link_d    = '0;
							res_pay_d     = '0;
							done_d        = 1'b1;
							state_d       = S_IDLE;
						end else begin
							prev_d  = cur_q;
							rd_en   = 1'b1;
							rd_addr = nl[SLOT_W-1:0];
							cur_d   = nl[SLOT_W-1:0];
							state_d = S_VIC;
						end
					end
					K_READ: begin
						res_status_d  = ST_OK;
						res_touched_d = cur_q;
						res_link_d    = lk_rdata;
						res_pay_d     = pl_rdata;
						done_d        = 1'b1;
						state_d       = S_IDLE;
					end
					default: begin
						res_status_d  = ST_BAD;
						res_touched_d = '0;
						res_link_d    = '0;
						res_pay_d     = '0;
						done_d        = 1'b1;
						state_d       = S_IDLE;
					end
				endcase
			end

			S_VIC: begin
				// cur_q is the victim candidate, prev_q its predecessor
				if (op_q == K_DEL_TAIL && nl != END_LINK) begin
					prev_d  = cur_q;
					rd_en   = 1'b1;
					rd_addr = nl[SLOT_W-1:0];
					cur_d   = nl[SLOT_W-1:0];
				end else begin
					lk_we         = 1'b1;
					lk_waddr      = prev_q;
					lk_wdata      = nl;
					free_d[cur_q] = 1'b1;
					count_d       = count_q - CNT_W'(1);
					res_status_d  = ST_OK;
					res_touched_d = cur_q;
					res_link_d    = FREE_LINK;
					res_pay_d     = pl_rdata;
					done_d        = 1'b1;
					state_d       = S_IDLE;
				end
			end

			S_FIX: begin
				// hook the new slot behind its predecessor
				lk_we    = 1'b1;
				lk_waddr = cur_q;
				lk_wdata = LINK_W'(new_q);
				done_d   = 1'b1;
				state_d  = S_IDLE;
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= END_LINK;
			count_q <= '0;
			free_q  <= '1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
			free_q  <= free_d;
			done_q  <= done_d;
		end
	end

	// operand and result registers
	always_ff @(posedge clk) begin
		op_q          <= op_d;
		slot_q        <= slot_d;
		pay_q         <= pay_d;
		cur_q         <= cur_d;
		prev_q        <= prev_d;
		new_q         <= new_d;
		res_status_q  <= res_status_d;
		res_touched_q <= res_touched_d;
		res_link_q    <= res_link_d;
		res_pay_q     <= res_pay_d;
	end

	// outputs; head and count are already final while done is high
	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign status       = res_status_q;
	assign touched_slot = res_touched_q;
	assign link_out     = res_link_q;
	assign payload_out  = res_pay_q;
	assign entry_count  = count_q;
	assign head_slot    = head_q;

	// free marks and entry count stay in step
	a_count_free: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(count_q) + $countones(free_q)) == ENTRIES)
		else $error("entry count disagrees with free marks");

	// empty head exactly when the count is zero
	a_head_count: assert property (@(posedge clk) disable iff (!arst_n)
		(head_q == END_LINK) == (count_q == '0))
		else $error("head and count disagree on empty list");

	// a result goes out only with the sequencer back at idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("result strobe while sequencer busy");

	// no allocation without a free slot
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		pl_we |-> free_q[low_idx])
		else $error("insert into an occupied slot");

endmodule

/* dv/tb.sv */
// Testbench for static_linked_list_engine_unit: random list traffic checked against a shadow list.
`timescale 1ns / 1ps

module tb;
	import slle_pkg::*;

	// Kind code with no operation behind it
	localparam kind_t K_NONE = 3'd7;
	localparam int RAND_ITEMS = 1380;
	localparam int CALM_ITEMS = 150;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		kind_t k;
		slot_t s;
		pay_t  p;
	} list_cmd_t;

	typedef struct packed {
		status_t status;
		slot_t   touched;
		link_t   link;
		pay_t    pay;
		cnt_t    count;
		link_t   head;
	} list_report_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	kind_t   kind = K_ADD_HEAD;
	slot_t   slot = '0;
	pay_t    payload = '0;
	logic    done;
	status_t status;
	slot_t   touched_slot;
	link_t   link_out;
	pay_t    payload_out;
	cnt_t    entry_count;
	link_t   head_slot;

	// Pending commands and the reports they will produce
	list_cmd_t    cmd_q[$];
	list_report_t report_q[$];

	// Shadow copy of the list
	pay_t  shadow_pay[ENTRIES];
	link_t shadow_link[ENTRIES];
	bit    shadow_free[ENTRIES] = '{default: 1'b1};
	link_t shadow_head = END_LINK;
	cnt_t  shadow_count = '0;

	bit took_word = 1'b0;
	bit rest_en = 1'b1;
	int fail_count = 0;

	static_linked_list_engine_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.kind         (kind),
		.slot         (slot),
		.payload      (payload),
		.done         (done),
		.status       (status),
		.touched_slot (touched_slot),
		.link_out     (link_out),
		.payload_out  (payload_out),
		.entry_count  (entry_count),
		.head_slot    (head_slot)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Successor of a slot; anything out of range reads as end
	function automatic link_t follow(input link_t s);
		if (s >= ENTRIES)
			return END_LINK;
		return (shadow_link[s[SLOT_W-1:0]] < ENTRIES) ? shadow_link[s[SLOT_W-1:0]] : END_LINK;
	endfunction

	function automatic bit live(input slot_t s);
		return !shadow_free[s];
	endfunction

	// Take the lowest free slot; callers have ruled out a full list
	function automatic slot_t claim_slot(input pay_t p, input link_t nxt);
		slot_t n;
		n = '0;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (shadow_free[i])
				n = slot_t'(i);
		shadow_pay[n] = p;
		shadow_link[n] = nxt;
		shadow_free[n] = 1'b0;
		shadow_count++;
		return n;
	endfunction

	function automatic pay_t free_slot(input slot_t s);
		shadow_link[s] = FREE_LINK;
		shadow_free[s] = 1'b1;
		if (shadow_count > 0)
			shadow_count--;
		return shadow_pay[s];
	endfunction

	// Apply one command to the shadow list and return the report it gives
	task automatic list_op_outcome(input kind_t k_in, input slot_t s, input pay_t p,
			output list_report_t r);
		kind_t k;
		bit    empty;
		bit    full;
		link_t prev;
		link_t victim;
		slot_t n;
		int    steps;
		r = '0;
		k = k_in;
		empty = shadow_head >= ENTRIES;
		full = shadow_count >= ENTRIES;
		// Tail operations on short lists fall back to head operations
		if (k == K_ADD_TAIL && empty)
			k = K_ADD_HEAD;
		if (k == K_DEL_TAIL && !empty && follow(shadow_head) == END_LINK)
			k = K_DEL_HEAD;
		case (k)
			K_ADD_HEAD: begin
				if (full) begin
					r.status = ST_FULL;
				end else begin
					n = claim_slot(p, empty ? END_LINK : shadow_head);
					shadow_head = link_t'(n);
					r.touched = n;
					r.link = shadow_link[n];
				end
			end
			K_ADD_AFTER, K_ADD_TAIL: begin
				if (k == K_ADD_AFTER && !live(s)) begin
					r.status = ST_BAD;
				end else if (full) begin
					r.status = ST_FULL;
				end else begin
					if (k == K_ADD_AFTER) begin
						prev = link_t'(s);
					end else begin
						prev = shadow_head;
						steps = 0;
						while (follow(prev) != END_LINK && steps < ENTRIES) begin
							prev = follow(prev);
							steps++;
						end
					end
					n = claim_slot(p, follow(prev));
					shadow_link[prev[SLOT_W-1:0]] = link_t'(n);
					r.touched = n;
					r.link = shadow_link[n];
				end
			end
			K_DEL_HEAD: begin
				if (empty) begin
					r.status = ST_EMPTY;
				end else begin
					r.touched = shadow_head[SLOT_W-1:0];
					shadow_head = follow(shadow_head);
					r.pay = free_slot(r.touched);
					r.link = FREE_LINK;
				end
			end
			K_DEL_AFTER, K_DEL_TAIL: begin
				if (k == K_DEL_AFTER && !live(s)) begin
					r.status = ST_BAD;
				end else if (k == K_DEL_TAIL && empty) begin
					r.status = ST_EMPTY;
				end else begin
					if (k == K_DEL_AFTER) begin
						prev = link_t'(s);
					end else begin
						prev = shadow_head;
						steps = 0;
						while (follow(follow(prev)) != END_LINK && steps < ENTRIES) begin
							prev = follow(prev);
							steps++;
						end
					end
					victim = follow(prev);
					if (victim == END_LINK) begin
						r.status = ST_EMPTY;
					end else begin
						shadow_link[prev[SLOT_W-1:0]] = follow(victim);
						r.touched = victim[SLOT_W-1:0];
						r.pay = free_slot(r.touched);
						r.link = FREE_LINK;
					end
				end
			end
			K_READ: begin
				if (!live(s)) begin
					r.status = ST_BAD;
				end else begin
					r.touched = s;
					r.link = shadow_link[s];
					r.pay = shadow_pay[s];
				end
			end
			default: begin
				r.status = ST_BAD;
			end
		endcase
		r.count = shadow_count;
		r.head = shadow_head;
	endtask

	function automatic list_cmd_t cmd(input kind_t k, input slot_t s, input pay_t p);
		list_cmd_t c;
		c.k = k;
		c.s = s;
		c.p = p;
		return c;
	endfunction

	// Random command; mode 0 grows the list, 1 shrinks it, 2 mixes
	function automatic list_cmd_t rand_cmd(input int mode);
		list_cmd_t c;
		slot_t     live_q[$];
		int        roll;
		int        ins_pct;
		for (int i = 0; i < ENTRIES; i++)
			if (!shadow_free[i])
				live_q.push_back(slot_t'(i));
		ins_pct = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
		roll = $urandom_range(0, 99);
		if (roll == 0)
			c.k = K_NONE;
		else if (roll <= ins_pct)
			c.k = kind_t'(K_ADD_HEAD + $urandom_range(0, 2));
		else if (roll < 91)
			c.k = kind_t'(K_DEL_HEAD + $urandom_range(0, 2));
		else
			c.k = K_READ;
		// Mostly aim at slots in the list so that slot operations go through
		if (live_q.size() > 0 && $urandom_range(0, 4) != 0)
			c.s = live_q[$urandom_range(0, live_q.size() - 1)];
		else
			c.s = slot_t'($urandom);
		case ($urandom_range(0, 9))
			0: c.p = '0;
			1: c.p = '1;
			default: c.p = {$urandom, $urandom};
		endcase
		return c;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// Driver: one word at a time, random rests between words
	always @(negedge clk) begin
		int gap;
		bit word_out;
		list_cmd_t c;
		if (arst_n) begin
			if (took_word) begin
				took_word = 1'b0;
				word_out = 1'b0;
				if (rest_en && $urandom_range(0, 3) == 0)
					gap = $urandom_range(1, 9);
			end
			if (word_out) begin
				// hold the current word until the block takes it
			end else if (gap == 0 && cmd_q.size() > 0) begin
				c = cmd_q.pop_front();
				kind <= c.k;
				slot <= c.s;
				payload <= c.p;
				word_out = 1'b1;
			end else begin
				if (gap > 0)
					gap--;
				kind <= kind_t'($urandom);
				slot <= slot_t'($urandom);
				payload <= {$urandom, $urandom};
			end
			start <= word_out;
		end
	end

	// Monitor: check results, then record accepted words
	always @(posedge clk) begin
		list_report_t got;
		list_report_t want;
		if (arst_n) begin
			if (done) begin
				if (report_q.size() == 0) begin
					$error("result with none pending");
					fail_count++;
				end else begin
					want = report_q.pop_front();
					check_field("status", want.status, status);
					check_field("touched_slot", want.touched, touched_slot);
					check_field("link_out", want.link, link_out);
					check_field("payload_out", want.pay, payload_out);
					check_field("entry_count", want.count, entry_count);
					check_field("head_slot", want.head, head_slot);
				end
			end
			if (start && !busy) begin
				list_op_outcome(kind, slot, payload, got);
				report_q.push_back(got);
				took_word = 1'b1;
			end
		end
	end

	// Stimulus and end of run
	initial begin
		int n;
		int mode;
		int span;
		n = 0;
		// Directed: empty-list errors, tail fallbacks, slot checks, odd kind
		cmd_q.push_back(cmd(K_READ, 0, '0));
		cmd_q.push_back(cmd(K_DEL_HEAD, 0, '0));
		cmd_q.push_back(cmd(K_DEL_TAIL, 0, '0));
		cmd_q.push_back(cmd(K_DEL_AFTER, 0, '0));
		cmd_q.push_back(cmd(K_ADD_AFTER, 3, '1));
		cmd_q.push_back(cmd(K_ADD_TAIL, 0, '1));
		cmd_q.push_back(cmd(K_ADD_HEAD, 15, '0));
		cmd_q.push_back(cmd(K_ADD_AFTER, 0, 64'hA5A5_5A5A_0F0F_F0F0));
		cmd_q.push_back(cmd(K_ADD_TAIL, 7, {$urandom, $urandom}));
		cmd_q.push_back(cmd(K_READ, 0, '0));
		cmd_q.push_back(cmd(K_READ, 15, '0));
		cmd_q.push_back(cmd(K_DEL_AFTER, 3, '0));
		cmd_q.push_back(cmd(K_DEL_AFTER, 1, '0));
		cmd_q.push_back(cmd(K_ADD_HEAD, 0, 64'h5555_AAAA_5555_AAAA));
		cmd_q.push_back(cmd(K_NONE, 15, '1));
		cmd_q.push_back(cmd(K_DEL_TAIL, 0, '0));
		cmd_q.push_back(cmd(K_DEL_HEAD, 0, '0));
		cmd_q.push_back(cmd(K_DEL_TAIL, 0, '0));
		cmd_q.push_back(cmd(K_DEL_TAIL, 0, '0));
		cmd_q.push_back(cmd(K_READ, 1, '0));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Random phases that fill, drain or churn the list
		while (n < RAND_ITEMS) begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(30, 90);
			if (n < RAND_ITEMS - CALM_ITEMS)
				rest_en = $urandom_range(0, 3) != 0;
			for (int j = 0; j < span && n < RAND_ITEMS; j++) begin
				while (cmd_q.size() >= 2)
					@(negedge clk);
				if (n >= RAND_ITEMS - CALM_ITEMS)
					rest_en = 1'b0;
				cmd_q.push_back(rand_cmd(mode));
				n++;
			end
		end

		while (cmd_q.size() != 0 || start || report_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Run limit
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
